[hdl/gdawc_pkg.sv]
// Shared types, constants and the control store for the calendar unit.
// Used by gdawc_seq, gdawc_dp and gregorian_date_add_and_week_count.
package gdawc_pkg;

	// Widths
	localparam int unsigned STEP_W = 5;   // control store address
	localparam int unsigned DAY_W  = 17;  // day accumulator: 31 + 65535
	localparam int unsigned YR_W   = 15;  // year incl. carry past 16383
	localparam int unsigned Q_W    = 6;   // quotient by 400
	localparam int unsigned ACC_W  = 24;  // signed serial difference
	localparam int unsigned X_W    = 22;  // non-negative day difference
	localparam int unsigned PROD_W = 2 * X_W;
	localparam int unsigned WK_W   = 20;
	localparam int unsigned REM_W  = X_W + 2;
	localparam int unsigned ST_W   = 2;

	// Calendar constants
	localparam int unsigned YEAR_CYCLE    = 400;
	localparam int unsigned CENTURY       = 100;
	localparam int unsigned YEAR_MAX      = 9999;
	localparam int unsigned MONTHS        = 12;
	localparam int unsigned DAYS_PER_YEAR = 365;
	localparam int unsigned WEEK_DAYS     = 7;
	localparam int unsigned FEB_LONG      = 29;
	localparam int unsigned FEB_SHORT     = 28;
	localparam int unsigned MON_LONG      = 31;
	localparam int unsigned MON_SHORT     = 30;

	// Reciprocal of 7, rounded down; the quotient is low by at most one
	localparam int unsigned RECIP_SH = 24;
	localparam logic [X_W-1:0] RECIP7 = X_W'((64'd1 << RECIP_SH) / 64'd7);

	// Result status codes
	localparam logic [ST_W-1:0] ST_OK  = 2'd0;
	localparam logic [ST_W-1:0] ST_INV = 2'd1;
	localparam logic [ST_W-1:0] ST_OVF = 2'd2;

	typedef logic [3:0] op_t;
	typedef logic [2:0] cond_t;
	typedef logic [STEP_W-1:0] step_t;

	// Datapath operations
	localparam op_t OP_NOP    = 4'd0;
	localparam op_t OP_LOAD_A = 4'd1;   // working date from A (plus day count in mode 0)
	localparam op_t OP_LOAD_B = 4'd2;   // working date from B
	localparam op_t OP_DIV    = 4'd3;   // one subtract-400 step
	localparam op_t OP_CARRY  = 4'd4;   // one month of day carry
	localparam op_t OP_SERY   = 4'd5;   // shifted year for the day serial
	localparam op_t OP_ACC_Y  = 4'd6;   // serial term 365*Y + Y/4
	localparam op_t OP_ACC_Q  = 4'd7;   // serial term -Y/100 + Y/400
	localparam op_t OP_ACC_D  = 4'd8;   // serial term month offset + day - 1
	localparam op_t OP_MUL    = 4'd9;   // difference times reciprocal of 7
	localparam op_t OP_FIX    = 4'd10;  // quotient correction
	localparam op_t OP_E_DATE = 4'd11;  // emit resulting date
	localparam op_t OP_E_WEEK = 4'd12;  // emit week count
	localparam op_t OP_E_NEG  = 4'd13;  // emit -1, A after B
	localparam op_t OP_E_INV  = 4'd14;  // emit invalid status
	localparam op_t OP_E_OVF  = 4'd15;  // emit overflow status

	// Jump conditions
	localparam cond_t C_NONE  = 3'd0;
	localparam cond_t C_INV   = 3'd1;
	localparam cond_t C_TGE   = 3'd2;
	localparam cond_t C_DGT   = 3'd3;
	localparam cond_t C_YOVF  = 3'd4;
	localparam cond_t C_MODE0 = 3'd5;
	localparam cond_t C_NEG   = 3'd6;

	// Program addresses
	localparam step_t L_LOAD_A  = 5'd0;
	localparam step_t L_DIV_A   = 5'd1;
	localparam step_t L_CARRY_A = 5'd2;
	localparam step_t L_OVF_A   = 5'd3;
	localparam step_t L_MODE    = 5'd4;
	localparam step_t L_SERY_A  = 5'd5;
	localparam step_t L_DIVS_A  = 5'd6;
	localparam step_t L_ACCY_A  = 5'd7;
	localparam step_t L_ACCQ_A  = 5'd8;
	localparam step_t L_ACCD_A  = 5'd9;
	localparam step_t L_LOAD_B  = 5'd10;
	localparam step_t L_DIV_B   = 5'd11;
	localparam step_t L_CARRY_B = 5'd12;
	localparam step_t L_OVF_B   = 5'd13;
	localparam step_t L_SERY_B  = 5'd14;
	localparam step_t L_DIVS_B  = 5'd15;
	localparam step_t L_ACCY_B  = 5'd16;
	localparam step_t L_ACCQ_B  = 5'd17;
	localparam step_t L_ACCD_B  = 5'd18;
	localparam step_t L_SIGN    = 5'd19;
	localparam step_t L_MUL     = 5'd20;
	localparam step_t L_FIX     = 5'd21;
	localparam step_t L_E_WEEK  = 5'd22;
	localparam step_t L_E_DATE  = 5'd23;
	localparam step_t L_E_NEG   = 5'd24;
	localparam step_t L_E_INV   = 5'd25;
	localparam step_t L_E_OVF   = 5'd26;

	typedef struct packed {
		op_t   op;
		logic  sub;
		cond_t cond;
		step_t tgt;
	} uword_t;

	typedef struct packed {
		logic inv;
		logic t_ge;
		logic d_gt;
		logic y_ovf;
		logic mode0;
		logic neg;
	} flags_t;

	typedef struct packed {
		logic run;
		op_t  op;
		logic sub;
	} dp_ctl_t;

	function automatic logic is_emit(input op_t op);
		return op == OP_E_DATE || op == OP_E_WEEK || op == OP_E_NEG ||
			op == OP_E_INV || op == OP_E_OVF;
	endfunction

	// Leap test from year mod 400
	function automatic logic leap_r(input logic [8:0] r);
		return r[1:0] == 2'b00 && r != 9'(CENTURY) && r != 9'(2 * CENTURY) &&
			r != 9'(3 * CENTURY);
	endfunction

	// (year mod 400) / 100
	function automatic logic [1:0] hundreds(input logic [8:0] r);
		logic [1:0] h;
		if (r >= 9'(3 * CENTURY)) h = 2'd3;
		else if (r >= 9'(2 * CENTURY)) h = 2'd2;
		else if (r >= 9'(CENTURY)) h = 2'd1;
		else h = 2'd0;
		return h;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] n;
		if (m == 4'd2) n = leap ? 5'(FEB_LONG) : 5'(FEB_SHORT);
		else if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11) n = 5'(MON_SHORT);
		else n = 5'(MON_LONG);
		return n;
	endfunction

	// Days before the month in a year starting in March
	function automatic logic [8:0] month_off(input logic [3:0] m);
		logic [8:0] v;
		case (m)
			4'd3:    v = 9'd0;
			4'd4:    v = 9'd31;
			4'd5:    v = 9'd61;
			4'd6:    v = 9'd92;
			4'd7:    v = 9'd122;
			4'd8:    v = 9'd153;
			4'd9:    v = 9'd184;
			4'd10:   v = 9'd214;
			4'd11:   v = 9'd245;
			4'd12:   v = 9'd275;
			4'd1:    v = 9'd306;
			4'd2:    v = 9'd337;
			default: v = 9'd0;
		endcase
		return v;
	endfunction

	function automatic logic date_ok(input logic [4:0] d, input logic [3:0] m);
		return d != 5'd0 && m >= 4'd1 && m <= 4'(MONTHS);
	endfunction

	function automatic uword_t uw(input op_t op, input logic sub, input cond_t cond,
		input step_t tgt);
		uword_t w;
		w.op = op;
		w.sub = sub;
		w.cond = cond;
		w.tgt = tgt;
		return w;
	endfunction

	// Control store: a taken condition jumps to tgt, otherwise the next step
	function automatic uword_t ucode(input step_t a);
		uword_t w;
		case (a)
			L_LOAD_A:  w = uw(OP_LOAD_A, 1'b0, C_INV, L_E_INV);
			L_DIV_A:   w = uw(OP_DIV, 1'b0, C_TGE, L_DIV_A);
			L_CARRY_A: w = uw(OP_CARRY, 1'b0, C_DGT, L_CARRY_A);
			L_OVF_A:   w = uw(OP_NOP, 1'b0, C_YOVF, L_E_OVF);
			L_MODE:    w = uw(OP_NOP, 1'b0, C_MODE0, L_E_DATE);
			L_SERY_A:  w = uw(OP_SERY, 1'b0, C_NONE, L_SERY_A);
			L_DIVS_A:  w = uw(OP_DIV, 1'b0, C_TGE, L_DIVS_A);
			L_ACCY_A:  w = uw(OP_ACC_Y, 1'b1, C_NONE, L_ACCY_A);
			L_ACCQ_A:  w = uw(OP_ACC_Q, 1'b1, C_NONE, L_ACCQ_A);
			L_ACCD_A:  w = uw(OP_ACC_D, 1'b1, C_NONE, L_ACCD_A);
			L_LOAD_B:  w = uw(OP_LOAD_B, 1'b0, C_NONE, L_LOAD_B);
			L_DIV_B:   w = uw(OP_DIV, 1'b0, C_TGE, L_DIV_B);
			L_CARRY_B: w = uw(OP_CARRY, 1'b0, C_DGT, L_CARRY_B);
			L_OVF_B:   w = uw(OP_NOP, 1'b0, C_YOVF, L_E_OVF);
			L_SERY_B:  w = uw(OP_SERY, 1'b0, C_NONE, L_SERY_B);
			L_DIVS_B:  w = uw(OP_DIV, 1'b0, C_TGE, L_DIVS_B);
			L_ACCY_B:  w = uw(OP_ACC_Y, 1'b0, C_NONE, L_ACCY_B);
			L_ACCQ_B:  w = uw(OP_ACC_Q, 1'b0, C_NONE, L_ACCQ_B);
			L_ACCD_B:  w = uw(OP_ACC_D, 1'b0, C_NONE, L_ACCD_B);
			L_SIGN:    w = uw(OP_NOP, 1'b0, C_NEG, L_E_NEG);
			L_MUL:     w = uw(OP_MUL, 1'b0, C_NONE, L_MUL);
			L_FIX:     w = uw(OP_FIX, 1'b0, C_NONE, L_FIX);
			L_E_WEEK:  w = uw(OP_E_WEEK, 1'b0, C_NONE, L_E_WEEK);
			L_E_DATE:  w = uw(OP_E_DATE, 1'b0, C_NONE, L_E_DATE);
			L_E_NEG:   w = uw(OP_E_NEG, 1'b0, C_NONE, L_E_NEG);
			L_E_INV:   w = uw(OP_E_INV, 1'b0, C_NONE, L_E_INV);
			L_E_OVF:   w = uw(OP_E_OVF, 1'b0, C_NONE, L_E_OVF);
			default:   w = uw(OP_E_INV, 1'b0, C_NONE, L_E_INV);
		endcase
		return w;
	endfunction

endpackage

[hdl/gdawc_seq.sv]
// Microcode sequencer: step counter, control store and conditional jumps.
// Depends on gdawc_pkg.
module gdawc_seq
	import gdawc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    hold,
	input  flags_t  flags,
	output dp_ctl_t ctl,
	output logic    busy
);

	logic   busy_q;
	step_t  step_q;
	uword_t word;
	logic   taken;

	assign word = ucode(step_q);

	// Condition select
	always_comb begin
		case (word.cond)
			C_INV:   taken = flags.inv;
			C_TGE:   taken = flags.t_ge;
			C_DGT:   taken = flags.d_gt;
			C_YOVF:  taken = flags.y_ovf;
			C_MODE0: taken = flags.mode0;
			C_NEG:   taken = flags.neg;
			default: taken = 1'b0;
		endcase
	end

	// Step counter; an emit step waits for the output register, then ends the run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= L_LOAD_A;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= L_LOAD_A;
		end else if (busy_q) begin
			if (is_emit(word.op)) begin
				if (!hold) busy_q <= 1'b0;
			end else begin
				step_q <= taken ? word.tgt : step_q + 1'b1;
			end
		end
	end

	assign ctl  = '{run: busy_q, op: word.op, sub: word.sub};
	assign busy = busy_q;

endmodule

[hdl/gdawc_dp.sv]
// Datapath: operand capture, day carry, mod-400 divider, serial accumulator
// and divide-by-7. Depends on gdawc_pkg; driven by gdawc_seq.
module gdawc_dp
	import gdawc_pkg::*;
(
	input  logic                clk,
	input  logic                start,
	input  dp_ctl_t             ctl,
	input  logic                mode,
	input  logic [4:0]          day_a,
	input  logic [3:0]          month_a,
	input  logic [13:0]         year_a,
	input  logic [4:0]          day_b,
	input  logic [3:0]          month_b,
	input  logic [13:0]         year_b,
	input  logic [15:0]         days_to_add,
	output flags_t              flags,
	output logic [4:0]          res_day,
	output logic [3:0]          res_month,
	output logic [13:0]         res_year,
	output logic [WK_W-1:0]     res_week
);

	// Captured operands
	logic        mode_q, inv_q;
	logic [4:0]  da_q, db_q;
	logic [3:0]  ma_q, mb_q;
	logic [13:0] ya_q, yb_q;
	logic [15:0] add_q;

	// Working registers
	logic [DAY_W-1:0]        d_q;
	logic [3:0]              m_q;
	logic [YR_W-1:0]         y_q, t_q;
	logic [Q_W-1:0]          q_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [PROD_W-1:0]       prod_q;
	logic [WK_W-1:0]         wk_q;

	logic                    leap;
	logic [4:0]              mlen;
	logic [YR_W-1:0]         y_shift;
	logic signed [ACC_W-1:0] term_y, term_q, term_d, term, acc_nx;
	logic [X_W-1:0]          diff;
	logic [WK_W-1:0]         q7;
	logic [REM_W-1:0]        q7x7, rem;

	// Month length from the running year mod 400
	assign leap = leap_r(t_q[8:0]);
	assign mlen = month_len(m_q, leap);

	assign flags.inv   = inv_q;
	assign flags.t_ge  = t_q >= YR_W'(YEAR_CYCLE);
	assign flags.d_gt  = d_q > DAY_W'(mlen);
	assign flags.y_ovf = y_q > YR_W'(YEAR_MAX);
	assign flags.mode0 = !mode_q;
	assign flags.neg   = acc_q[ACC_W-1];

	// Serial terms: 365*Y + Y/4 - Y/100 + Y/400 + month offset + day - 1
	assign y_shift = y_q + YR_W'(YEAR_CYCLE) - YR_W'(m_q <= 4'd2);
	assign term_y  = $signed(ACC_W'(y_q) * ACC_W'(DAYS_PER_YEAR) + ACC_W'(y_q[YR_W-1:2]));
	assign term_q  = -$signed(ACC_W'(q_q) * ACC_W'(3) + ACC_W'(hundreds(t_q[8:0])));
	assign term_d  = $signed(ACC_W'(month_off(m_q)) + ACC_W'(d_q) - ACC_W'(1));

	always_comb begin
		case (ctl.op)
			OP_ACC_Y: term = term_y;
			OP_ACC_Q: term = term_q;
			OP_ACC_D: term = term_d;
			default:  term = '0;
		endcase
	end

	// A's serial is subtracted, B's added
	assign acc_nx = ctl.sub ? acc_q - term : acc_q + term;

	// Divide by 7: estimate from the registered product, then one correction
	assign diff = acc_q[X_W-1:0];
	assign q7   = prod_q[PROD_W-1 -: WK_W];
	assign q7x7 = (REM_W'(q7) << 3) - REM_W'(q7);
	assign rem  = REM_W'(diff) - q7x7;

	// Operand capture on transfer
	always_ff @(posedge clk) begin
		if (start) begin
			mode_q <= mode;
			da_q   <= day_a;
			ma_q   <= month_a;
			ya_q   <= year_a;
			db_q   <= day_b;
			mb_q   <= month_b;
			yb_q   <= year_b;
			add_q  <= days_to_add;
			inv_q  <= !date_ok(day_a, month_a) || (mode && !date_ok(day_b, month_b));
		end
	end

	// Microcoded operations
	always_ff @(posedge clk) begin
		if (ctl.run) begin
			case (ctl.op)
				OP_LOAD_A: begin
					d_q   <= mode_q ? DAY_W'(da_q) : DAY_W'(da_q) + DAY_W'(add_q);
					m_q   <= ma_q;
					y_q   <= YR_W'(ya_q);
					t_q   <= YR_W'(ya_q);
					q_q   <= '0;
					acc_q <= '0;
				end
				OP_LOAD_B: begin
					d_q <= DAY_W'(db_q);
					m_q <= mb_q;
					y_q <= YR_W'(yb_q);
					t_q <= YR_W'(yb_q);
					q_q <= '0;
				end
				OP_DIV: begin
					if (flags.t_ge) begin
						t_q <= t_q - YR_W'(YEAR_CYCLE);
						q_q <= q_q + 1'b1;
					end
				end
				OP_CARRY: begin
					if (flags.d_gt) begin
						d_q <= d_q - DAY_W'(mlen);
						if (m_q == 4'(MONTHS)) begin
							m_q <= 4'd1;
							y_q <= y_q + 1'b1;
							t_q <= (t_q == YR_W'(YEAR_CYCLE - 1)) ? '0 : t_q + 1'b1;
						end else begin
							m_q <= m_q + 1'b1;
						end
					end
				end
				OP_SERY: begin
					y_q <= y_shift;
					t_q <= y_shift;
					q_q <= '0;
				end
				OP_ACC_Y, OP_ACC_Q, OP_ACC_D: acc_q <= acc_nx;
				OP_MUL: prod_q <= PROD_W'(diff) * PROD_W'(RECIP7);
				OP_FIX: wk_q <= (rem >= REM_W'(WEEK_DAYS)) ? q7 + 1'b1 : q7;
				default: ;
			endcase
		end
	end

	assign res_day   = d_q[4:0];
	assign res_month = m_q;
	assign res_year  = y_q[13:0];
	assign res_week  = wk_q;

endmodule

[hdl/gregorian_date_add_and_week_count.sv]
// Gregorian date add / week count, microcoded; one item in flight at a time.
// Mode 0: load A plus the day count, divide the year by 400, carry months, check overflow, emit.
// Mode 1: for A, then B: load, divide, carry, check overflow, take Ya or Yb = year + 400, one
// less in Jan/Feb, divide it by 400 and add to the serial; then divide by 7. Early exits
// (invalid, overflow, A after B) are shorter; next transfer the cycle after the result loads.
// Reset (arst_n low, async) clears the sequencer and output valid; no clearing pass.
module gregorian_date_add_and_week_count
	import gdawc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               mode,
	input  logic [4:0]         day_a,
	input  logic [3:0]         month_a,
	input  logic [13:0]        year_a,
	input  logic [4:0]         day_b,
	input  logic [3:0]         month_b,
	input  logic [13:0]        year_b,
	input  logic [15:0]        days_to_add,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [4:0]         day_out,
	output logic [3:0]         month_out,
	output logic [13:0]        year_out,
	output logic signed [19:0] week_count,
	output logic [1:0]         status
);

	logic        busy, start, out_free, emit_fire;
	dp_ctl_t     ctl;
	flags_t      flags;
	logic [4:0]  res_day;
	logic [3:0]  res_month;
	logic [13:0] res_year;
	logic [WK_W-1:0] res_week;

	logic            out_valid_q;
	logic [4:0]      day_q;
	logic [3:0]      month_q;
	logic [13:0]     year_q;
	logic [WK_W-1:0] week_q;
	logic [ST_W-1:0] status_q;

	logic [4:0]      day_nx;
	logic [3:0]      month_nx;
	logic [13:0]     year_nx;
	logic [WK_W-1:0] week_nx;
	logic [ST_W-1:0] status_nx;

	assign in_stall  = busy;
	assign start     = in_valid && !busy;
	assign out_free  = !out_valid_q || !out_stall;
	assign emit_fire = ctl.run && is_emit(ctl.op) && out_free;

	gdawc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.hold   (!out_free),
		.flags  (flags),
		.ctl    (ctl),
		.busy   (busy)
	);

	gdawc_dp u_dp (
		.clk         (clk),
		.start       (start),
		.ctl         (ctl),
		.mode        (mode),
		.day_a       (day_a),
		.month_a     (month_a),
		.year_a      (year_a),
		.day_b       (day_b),
		.month_b     (month_b),
		.year_b      (year_b),
		.days_to_add (days_to_add),
		.flags       (flags),
		.res_day     (res_day),
		.res_month   (res_month),
		.res_year    (res_year),
		.res_week    (res_week)
	);

	// Output valid: set on emit, cleared on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result fields per emit kind; unused fields read zero
	always_comb begin
		day_nx    = '0;
		month_nx  = '0;
		year_nx   = '0;
		week_nx   = '0;
		status_nx = ST_OK;
		unique case (ctl.op)
			OP_E_DATE: begin
				day_nx   = res_day;
				month_nx = res_month;
				year_nx  = res_year;
			end
			OP_E_WEEK: week_nx = res_week;
			OP_E_NEG:  week_nx = '1;
			OP_E_INV:  status_nx = ST_INV;
			OP_E_OVF:  status_nx = ST_OVF;
			default: ;
		endcase
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (emit_fire) begin
			day_q    <= day_nx;
			month_q  <= month_nx;
			year_q   <= year_nx;
			week_q   <= week_nx;
			status_q <= status_nx;
		end
	end

	assign out_valid  = out_valid_q;
	assign day_out    = day_q;
	assign month_out  = month_q;
	assign year_out   = year_q;
	assign week_count = $signed(week_q);
	assign status     = status_q;

	// An accepted item keeps the input side closed while it runs
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> in_stall)
		else $error("sequencer not busy after input transfer");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_INV || status == ST_OVF))
		else $error("undefined status code");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |->
			day_out == 5'd0 && month_out == 4'd0 && year_out == 14'd0 && week_count == 20'sd0)
		else $error("error result carries nonzero fields");

	a_emit_idle_next: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire |=> !in_stall && out_valid)
		else $error("emit did not end the run");

endmodule

[verif/tb_gregorian_date_add_and_week_count.sv]
// Self-checking testbench for the Gregorian date add / week count unit.
// Depends on gdawc_pkg (status codes, calendar constants) and the top-level RTL.
`timescale 1ns / 1ps

module tb_gregorian_date_add_and_week_count;
	import gdawc_pkg::*;

	localparam logic MODE_ADD   = 1'b0;
	localparam logic MODE_WEEKS = 1'b1;

	localparam int N_RANDOM = 650;
	// Slowest item: subtract-400 steps for the largest year plus month carries for the largest
	// day count; the long output hold-off adds HOLD_LEN more. The limit allows several times that.
	localparam int WATCHDOG = 12000;
	localparam int DRAIN    = 2500;
	localparam int HOLD_LEN = 400;

	typedef struct packed {
		logic        mode;
		logic [4:0]  da;
		logic [3:0]  ma;
		logic [13:0] ya;
		logic [4:0]  db;
		logic [3:0]  mb;
		logic [13:0] yb;
		logic [15:0] add;
	} req_t;

	typedef struct packed {
		logic [4:0]         day;
		logic [3:0]         month;
		logic [13:0]        year;
		logic signed [19:0] weeks;
		logic [1:0]         st;
	} res_t;

	typedef struct packed {
		req_t req;
		logic fixed;
		res_t res;
	} vec_t;

	localparam res_t NO_RES = '0;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic mode = 1'b0;
	logic [4:0] day_a = '0;
	logic [3:0] month_a = '0;
	logic [13:0] year_a = '0;
	logic [4:0] day_b = '0;
	logic [3:0] month_b = '0;
	logic [13:0] year_b = '0;
	logic [15:0] days_to_add = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [4:0] day_out;
	logic [3:0] month_out;
	logic [13:0] year_out;
	logic signed [19:0] week_count;
	logic [1:0] status;

	res_t pending_q[$];
	vec_t directed_q[$];
	int errors = 0;
	int n_in = 0;
	int n_out = 0;
	int n_add = 0;
	int n_week = 0;
	int n_inv = 0;
	int n_ovf = 0;
	int n_neg = 0;
	int burst_left = 0;
	int idle_cycles = 0;
	bit hold_done = 1'b0;

	always #5 clk = ~clk;

	gregorian_date_add_and_week_count i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.day_a(day_a),
		.month_a(month_a),
		.year_a(year_a),
		.day_b(day_b),
		.month_b(month_b),
		.year_b(year_b),
		.days_to_add(days_to_add),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.day_out(day_out),
		.month_out(month_out),
		.year_out(year_out),
		.week_count(week_count),
		.status(status)
	);

	// ---------------------------------------------------------------- calendar math

	function automatic bit is_leap(input int unsigned y);
		return ((y % 4) == 0 && (y % CENTURY) != 0) || (y % YEAR_CYCLE) == 0;
	endfunction

	function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
		if (m == 2)
			return is_leap(y) ? FEB_LONG : FEB_SHORT;
		if (m == 4 || m == 6 || m == 9 || m == 11)
			return MON_SHORT;
		return MON_LONG;
	endfunction

	function automatic bit valid_date(input logic [4:0] d, input logic [3:0] m);
		return d != 0 && m >= 1 && m <= MONTHS;
	endfunction

	// Push surplus days into following months, wrapping December into a new year
	function automatic void roll_forward(inout int unsigned d, inout int unsigned m,
		inout int unsigned y);
		while (d > days_in_month(m, y)) begin
			d -= days_in_month(m, y);
			m++;
			if (m > MONTHS) begin
				m = 1;
				y++;
			end
		end
	endfunction

	// Days since a fixed epoch; year shifted by 400 years so nothing goes negative
	function automatic int unsigned day_number(input int unsigned d, input int unsigned m,
		input int unsigned y);
		int unsigned yy;
		int unsigned mp;
		yy = y + YEAR_CYCLE - ((m <= 2) ? 1 : 0);
		mp = (m > 2) ? (m - 3) : (m + 9);
		return DAYS_PER_YEAR * yy + yy / 4 - yy / CENTURY + yy / YEAR_CYCLE +
			(153 * mp + 2) / 5 + d - 1;
	endfunction

	// Expected result of one request
	function automatic res_t predict(input req_t r);
		res_t o;
		int unsigned d1, m1, y1, d2, m2, y2, s1, s2;
		o = '0;
		d1 = r.da;
		m1 = r.ma;
		y1 = r.ya;
		if (r.mode == MODE_ADD) begin
			if (!valid_date(r.da, r.ma)) begin
				o.st = ST_INV;
				return o;
			end
			d1 = d1 + r.add;
			roll_forward(d1, m1, y1);
			if (y1 > YEAR_MAX) begin
				o.st = ST_OVF;
			end else begin
				o.day = 5'(d1);
				o.month = 4'(m1);
				o.year = 14'(y1);
			end
			return o;
		end
		if (!valid_date(r.da, r.ma) || !valid_date(r.db, r.mb)) begin
			o.st = ST_INV;
			return o;
		end
		d2 = r.db;
		m2 = r.mb;
		y2 = r.yb;
		roll_forward(d1, m1, y1);
		roll_forward(d2, m2, y2);
		if (y1 > YEAR_MAX || y2 > YEAR_MAX) begin
			o.st = ST_OVF;
			return o;
		end
		s1 = day_number(d1, m1, y1);
		s2 = day_number(d2, m2, y2);
		o.weeks = (s1 > s2) ? -20'sd1 : 20'((s2 - s1) / WEEK_DAYS);
		return o;
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	function automatic req_t add_req(input int d, input int m, input int y, input int n);
		req_t r;
		r = '0;
		r.mode = MODE_ADD;
		r.da = 5'(d);
		r.ma = 4'(m);
		r.ya = 14'(y);
		r.add = 16'(n);
		return r;
	endfunction

	function automatic req_t week_req(input int da, input int ma, input int ya,
		input int db, input int mb, input int yb);
		req_t r;
		r = '0;
		r.mode = MODE_WEEKS;
		r.da = 5'(da);
		r.ma = 4'(ma);
		r.ya = 14'(ya);
		r.db = 5'(db);
		r.mb = 4'(mb);
		r.yb = 14'(yb);
		return r;
	endfunction

	function automatic res_t res_of(input int d, input int m, input int y, input int w,
		input logic [1:0] st);
		res_t o;
		o.day = 5'(d);
		o.month = 4'(m);
		o.year = 14'(y);
		o.weeks = 20'(w);
		o.st = st;
		return o;
	endfunction

	task automatic row(input req_t r, input bit fixed, input res_t e);
		vec_t v;
		v.req = r;
		v.fixed = fixed;
		v.res = e;
		directed_q.push_back(v);
	endtask

	function automatic logic [13:0] rand_year();
		int unsigned k;
		k = $urandom_range(0, 19);
		if (k == 0)
			return 14'd0;
		if (k == 1)
			return 14'($urandom_range(YEAR_MAX + 1, 16383));
		if (k == 2)
			return 14'($urandom_range(YEAR_MAX - 9, YEAR_MAX));
		return 14'($urandom_range(1, YEAR_MAX));
	endfunction

	// Mostly in-month days, some overlong ones that need carrying
	function automatic logic [4:0] rand_day(input logic [3:0] m, input logic [13:0] y);
		int unsigned len;
		int unsigned k;
		len = days_in_month(m, y);
		k = $urandom_range(0, 19);
		if (k < 3 && len < MON_LONG)
			return 5'($urandom_range(len + 1, MON_LONG));
		if (k == 3)
			return 5'd1;
		return 5'($urandom_range(1, len));
	endfunction

	function automatic logic [15:0] rand_count();
		int unsigned k;
		k = $urandom_range(0, 99);
		if (k < 55)
			return 16'($urandom_range(0, 400));
		if (k < 80)
			return 16'($urandom_range(0, 4000));
		if (k < 92)
			return 16'($urandom_range(0, 65535));
		if (k < 96)
			return 16'hFFFF;
		return 16'd0;
	endfunction

	// Mostly well-formed dates; one in ten items is raw noise on every field
	function automatic req_t rand_req();
		req_t r;
		r.mode = 1'($urandom_range(0, 1));
		r.da = 5'($urandom);
		r.ma = 4'($urandom);
		r.ya = 14'($urandom);
		r.db = 5'($urandom);
		r.mb = 4'($urandom);
		r.yb = 14'($urandom);
		r.add = 16'($urandom);
		if ($urandom_range(0, 99) >= 10) begin
			r.ma = 4'($urandom_range(1, MONTHS));
			r.ya = rand_year();
			r.da = rand_day(r.ma, r.ya);
			if ($urandom_range(0, 2) == 0) begin
				// B close to A: small week counts and A-after-B both show up
				r.yb = r.ya;
				r.mb = ($urandom_range(0, 1) == 1 && r.ma < MONTHS) ? r.ma + 4'd1 : r.ma;
			end else begin
				r.yb = rand_year();
				r.mb = 4'($urandom_range(1, MONTHS));
			end
			r.db = rand_day(r.mb, r.yb);
			r.add = rand_count();
		end
		return r;
	endfunction

	// Offer one request in bursts with random gaps; book its expected result
	task automatic put(input req_t r, input res_t e);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		mode <= r.mode;
		day_a <= r.da;
		month_a <= r.ma;
		year_a <= r.ya;
		day_b <= r.db;
		month_b <= r.mb;
		year_b <= r.yb;
		days_to_add <= r.add;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_q.push_back(e);
		n_in++;
		if (r.mode == MODE_ADD)
			n_add++;
		else
			n_week++;
		if (e.st == ST_INV)
			n_inv++;
		else if (e.st == ST_OVF)
			n_ovf++;
		else if (r.mode == MODE_WEEKS && e.weeks == -20'sd1)
			n_neg++;
	endtask

	// ---------------------------------------------------------------- sender

	initial begin
		req_t r;
		res_t e;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed rows: leap rules, extremes, invalid and overflow codes, A after B, short week counts
		row(add_req(29, 2, 2024, 0), 1'b1, res_of(29, 2, 2024, 0, ST_OK));
		row(add_req(28, 2, 2024, 1), 1'b0, NO_RES);
		row(add_req(28, 2, 2023, 1), 1'b0, NO_RES);
		row(add_req(28, 2, 1900, 1), 1'b0, NO_RES);
		row(add_req(28, 2, 2000, 1), 1'b0, NO_RES);
		row(add_req(1, 1, 1, 65535), 1'b0, NO_RES);
		row(add_req(31, 12, 9999, 1), 1'b1, res_of(0, 0, 0, 0, ST_OVF));
		row(add_req(31, 2, 2023, 0), 1'b0, NO_RES);
		row(add_req(0, 5, 2020, 10), 1'b1, res_of(0, 0, 0, 0, ST_INV));
		row(add_req(15, 13, 2020, 10), 1'b1, res_of(0, 0, 0, 0, ST_INV));
		row(add_req(1, 1, 0, 59), 1'b0, NO_RES);
		row(add_req(1, 1, 16383, 0), 1'b1, res_of(0, 0, 0, 0, ST_OVF));
		row(add_req(31, 12, 9999, 65535), 1'b1, res_of(0, 0, 0, 0, ST_OVF));
		row(add_req(0, 1, 16000, 0), 1'b1, res_of(0, 0, 0, 0, ST_INV));
		row(week_req(15, 6, 2020, 15, 6, 2020), 1'b1, res_of(0, 0, 0, 0, ST_OK));
		row(week_req(2, 1, 2024, 1, 1, 2024), 1'b1, res_of(0, 0, 0, -1, ST_OK));
		row(week_req(1, 1, 2024, 8, 1, 2024), 1'b1, res_of(0, 0, 0, 1, ST_OK));
		row(week_req(1, 1, 1, 31, 12, 9999), 1'b0, NO_RES);
		row(week_req(1, 1, 2020, 1, 15, 2020), 1'b1, res_of(0, 0, 0, 0, ST_INV));
		row(week_req(0, 3, 2020, 1, 4, 2020), 1'b1, res_of(0, 0, 0, 0, ST_INV));
		row(week_req(1, 1, 2020, 1, 1, 16383), 1'b1, res_of(0, 0, 0, 0, ST_OVF));
		row(week_req(1, 0, 16383, 1, 1, 2020), 1'b1, res_of(0, 0, 0, 0, ST_INV));
		row(week_req(31, 4, 2023, 31, 6, 2023), 1'b0, NO_RES);
		row(week_req(1, 1, 0, 1, 1, 1), 1'b0, NO_RES);
		row(week_req(1, 3, 2024, 7, 3, 2024), 1'b1, res_of(0, 0, 0, 0, ST_OK));

		foreach (directed_q[i]) begin
			e = directed_q[i].fixed ? directed_q[i].res : predict(directed_q[i].req);
			put(directed_q[i].req, e);
		end

		repeat (N_RANDOM) begin
			r = rand_req();
			put(r, predict(r));
		end
		in_valid <= 1'b0;

		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("Covered %0d date additions and %0d week counts (%0d directed).",
			n_add, n_week, directed_q.size());
		$display("Invalid: %0d, overflow: %0d, A after B: %0d, long output hold-off: %0d.",
			n_inv, n_ovf, n_neg, hold_done);
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// ---------------------------------------------------------------- receiver

	// Stall phases of random density, plus one long hold-off to back up the input
	initial begin
		int phase_len;
		int pct;
		@(posedge arst_n);
		forever begin
			phase_len = $urandom_range(20, 200);
			case ($urandom_range(0, 3))
				0: pct = 0;
				1: pct = 25;
				2: pct = 60;
				default: pct = 90;
			endcase
			repeat (phase_len) begin
				@(posedge clk);
				out_stall <= ($urandom_range(0, 99) < pct);
			end
			if (!hold_done && n_in >= 40) begin
				hold_done = 1'b1;
				@(posedge clk);
				out_stall <= 1'b1;
				repeat (HOLD_LEN) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- checking

	task automatic cmp(input string what, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		res_t e;
		if (arst_n && out_valid && !out_stall) begin
			n_out++;
			if (pending_q.size() == 0) begin
				$display("%0t: result transfer with nothing expected", $time);
				errors++;
			end else begin
				e = pending_q.pop_front();
				cmp("day_out", int'(e.day), int'(day_out));
				cmp("month_out", int'(e.month), int'(month_out));
				cmp("year_out", int'(e.year), int'(year_out));
				cmp("week_count", int'(e.weeks), int'(week_count));
				cmp("status", int'(e.st), int'(status));
			end
		end
	end

	// Watchdog: consecutive cycles with no transfer on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("%0t: no transfer for %0d cycles, %0d results outstanding",
					$time, WATCHDOG, pending_q.size());
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

endmodule

[sim.f]
hdl/gdawc_pkg.sv
hdl/gdawc_seq.sv
hdl/gdawc_dp.sv
hdl/gregorian_date_add_and_week_count.sv
verif/tb_gregorian_date_add_and_week_count.sv
